[rtl/rmrc_pkg.sv]
package rmrc_pkg;

	// Opcodes of an input beat
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Error codes
	localparam logic [3:0] ERR_OK       = 4'd0;
	localparam logic [3:0] ERR_ADDRESS  = 4'd1;
	localparam logic [3:0] ERR_CRC_EMPTY = 4'd2;
	localparam logic [3:0] ERR_CRC      = 4'd3;
	localparam logic [3:0] ERR_NO_REPLY = 4'd4;
	localparam logic [3:0] ERR_GET_SUB  = 4'd5;
	localparam logic [3:0] ERR_SET_SUB  = 4'd6;
	localparam logic [3:0] ERR_COMMAND  = 4'd7;
	localparam logic [3:0] ERR_STRAY    = 4'd8;

	// Reply kinds
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_STATUS   = 3'd1;
	localparam logic [2:0] KIND_CONFIG   = 3'd2;
	localparam logic [2:0] KIND_ERRORS   = 3'd3;
	localparam logic [2:0] KIND_VERSION  = 3'd4;
	localparam logic [2:0] KIND_CFG_ACK  = 3'd5;
	localparam logic [2:0] KIND_CMD_ACK  = 3'd6;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_DEVICE_ADDRESS   = 3'd0;
	localparam logic [2:0] REG_GET_COMMAND      = 3'd1;
	localparam logic [2:0] REG_SET_COMMAND      = 3'd2;
	localparam logic [2:0] REG_STATUS_SUBCODE   = 3'd3;
	localparam logic [2:0] REG_CONFIG_SUBCODE   = 3'd4;
	localparam logic [2:0] REG_ERRORS_SUBCODE   = 3'd5;
	localparam logic [2:0] REG_VERSION_SUBCODE  = 3'd6;
	localparam logic [2:0] REG_COMMANDS_SUBCODE = 3'd7;

	localparam int unsigned HDR_BYTES = 5;
	localparam logic [2:0]  POLL_LAST = 3'd6;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	// CRC-16/MODBUS nibble table (reflected polynomial 0xA001)
	localparam logic [15:0] CRC_NIB_TAB [16] = '{
		16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
		16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
	};

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
		logic       line_flag;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  error_code;
		logic [2:0]  reply_kind;
		logic [15:0] version_word;
		logic        request_kind;
		logic [7:0]  retry_count;
		logic [31:0] error_total;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] get_command;
		logic [7:0] set_command;
		logic [7:0] status_subcode;
		logic [7:0] config_subcode;
		logic [7:0] errors_subcode;
		logic [7:0] version_subcode;
		logic [7:0] commands_subcode;
	} cfg_regs_t;

	typedef struct packed {
		logic       fail;
		logic [3:0] code;
		logic [2:0] kind;
	} verdict_t;

endpackage

[rtl/rmrc_crc.sv]
module rmrc_crc (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	logic [15:0] c0;
	logic [15:0] c1;

	// Two nibble steps per byte
	assign c0      = crc_in ^ {8'h00, data};
	assign c1      = {4'h0, c0[15:4]} ^ rmrc_pkg::CRC_NIB_TAB[c0[3:0]];
	assign crc_out = {4'h0, c1[15:4]} ^ rmrc_pkg::CRC_NIB_TAB[c1[3:0]];

endmodule

[rtl/rmrc_judge.sv]
module rmrc_judge (
	input  rmrc_pkg::cfg_regs_t cfg,
	input  logic                no_reply,
	input  logic                residue_zero,
	input  logic                count_zero,
	input  logic [7:0]          hdr_addr,
	input  logic [7:0]          hdr_cmd,
	input  logic [7:0]          hdr_sub,
	output rmrc_pkg::verdict_t  verdict
);

	logic is_get;
	logic is_set;

	assign is_get = (hdr_cmd == cfg.get_command);
	assign is_set = (hdr_cmd == cfg.set_command);

	always_comb begin
		verdict = '{fail: 1'b1, code: rmrc_pkg::ERR_COMMAND, kind: rmrc_pkg::KIND_NONE};
		if (no_reply) begin
			verdict.code = rmrc_pkg::ERR_NO_REPLY;
		end else if (!residue_zero) begin
			verdict.code = count_zero ? rmrc_pkg::ERR_CRC_EMPTY : rmrc_pkg::ERR_CRC;
		end else if (hdr_addr != cfg.device_address) begin
			verdict.code = rmrc_pkg::ERR_ADDRESS;
		end else if (is_get && hdr_sub == cfg.status_subcode) begin
			verdict = '{fail: 1'b0, code: rmrc_pkg::ERR_OK, kind: rmrc_pkg::KIND_STATUS};
		end else if (is_get && hdr_sub == cfg.config_subcode) begin
			verdict = '{fail: 1'b0, code: rmrc_pkg::ERR_OK, kind: rmrc_pkg::KIND_CONFIG};
		end else if (is_get && hdr_sub == cfg.errors_subcode) begin
			verdict = '{fail: 1'b0, code: rmrc_pkg::ERR_OK, kind: rmrc_pkg::KIND_ERRORS};
		end else if (is_get && hdr_sub == cfg.version_subcode) begin
			verdict = '{fail: 1'b0, code: rmrc_pkg::ERR_OK, kind: rmrc_pkg::KIND_VERSION};
		end else if (is_set && hdr_sub == cfg.config_subcode) begin
			verdict = '{fail: 1'b0, code: rmrc_pkg::ERR_OK, kind: rmrc_pkg::KIND_CFG_ACK};
		end else if (is_set && hdr_sub == cfg.commands_subcode) begin
			verdict = '{fail: 1'b0, code: rmrc_pkg::ERR_OK, kind: rmrc_pkg::KIND_CMD_ACK};
		end else if (is_set) begin
			verdict.code = rmrc_pkg::ERR_SET_SUB;
		end else if (is_get) begin
			verdict.code = rmrc_pkg::ERR_GET_SUB;
		end
	end

endmodule

[rtl/rs485_master_reply_checker_core.sv]
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------------
// in      | input     | in_valid/in_stall   | in_data  (opcode, rx_byte, line_flag)
// out     | output    | out_valid/out_stall | out_data (error_code .. error_total)
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One beat enters s1 every cycle while in_stall is low; its result is loaded into the
// result register when s1 advances, and the result beat leaves from there.
// The poll/receive/judge update, CRC nibble lookups included, is one pass from s1.
// A stalled output holds the result register and s1; in_stall rises only while both
// are full and out_stall is high.
// Reset clears control state and restores register defaults; header bytes hold.
module rs485_master_reply_checker_core #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rmrc_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rmrc_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	localparam int CW = $clog2(BUFFER_BYTES);
	localparam logic [CW-1:0] COUNT_HOLD = CW'(BUFFER_BYTES - 2);

	// link phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_RCV  = 2'd2;

	rmrc_pkg::cfg_regs_t cfg_q;

	// input stage
	logic               valid_s1;
	rmrc_pkg::in_beat_t beat_s1;
	logic               advance;

	// block state
	logic [1:0]    phase_q,    phase_n;
	logic [15:0]   residue_q,  residue_n;
	logic [CW-1:0] count_q,    count_n;
	logic          stopped_q,  stopped_n;
	logic [2:0]    poll_q,     poll_n;
	logic [7:0]    retries_q,  retries_n;
	logic [31:0]   fsum_q,     fsum_n;
	logic [3:0]    error_q,    error_n;
	logic [2:0]    kind_q,     kind_n;
	logic          request_q,  request_n;
	logic [7:0]    hdr_q [rmrc_pkg::HDR_BYTES];

	// byte store path
	logic [15:0]   crc_src;
	logic [15:0]   crc_next;
	logic [CW-1:0] count_src;
	logic          hdr_we;

	// judging
	rmrc_pkg::verdict_t verdict;
	logic [7:0]         retries_inc;
	logic [32:0]        fsum_sum;

	rmrc_pkg::out_beat_t res;

	// Configuration registers; host must write only while no beat in flight; unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{device_address: 8'd1, get_command: 8'd3, set_command: 8'd6,
			           status_subcode: 8'd1, config_subcode: 8'd2, errors_subcode: 8'd3,
			           version_subcode: 8'd4, commands_subcode: 8'd5};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmrc_pkg::REG_DEVICE_ADDRESS:   cfg_q.device_address   <= cfg_data;
				rmrc_pkg::REG_GET_COMMAND:      cfg_q.get_command      <= cfg_data;
				rmrc_pkg::REG_SET_COMMAND:      cfg_q.set_command      <= cfg_data;
				rmrc_pkg::REG_STATUS_SUBCODE:   cfg_q.status_subcode   <= cfg_data;
				rmrc_pkg::REG_CONFIG_SUBCODE:   cfg_q.config_subcode   <= cfg_data;
				rmrc_pkg::REG_ERRORS_SUBCODE:   cfg_q.errors_subcode   <= cfg_data;
				rmrc_pkg::REG_VERSION_SUBCODE:  cfg_q.version_subcode  <= cfg_data;
				rmrc_pkg::REG_COMMANDS_SUBCODE: cfg_q.commands_subcode <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance s1 whenever the result register is free or being drained
	assign advance  = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_data;
		end
	end

	// The first byte of a reply restarts the residue and the count
	assign crc_src   = (phase_q == PH_WAIT) ? rmrc_pkg::CRC_INIT : residue_q;
	assign count_src = (phase_q == PH_WAIT) ? '0 : count_q;

	rmrc_crc u_crc (
		.crc_in  (crc_src),
		.data    (beat_s1.rx_byte),
		.crc_out (crc_next)
	);

	rmrc_judge u_judge (
		.cfg          (cfg_q),
		.no_reply     (phase_q == PH_WAIT),
		.residue_zero (residue_q == 16'h0000),
		.count_zero   (count_q == '0),
		.hdr_addr     (hdr_q[0]),
		.hdr_cmd      (hdr_q[1]),
		.hdr_sub      (hdr_q[2]),
		.verdict      (verdict)
	);

	assign retries_inc = (retries_q == 8'hFF) ? retries_q : retries_q + 8'd1;
	assign fsum_sum    = {1'b0, fsum_q} + {25'd0, retries_inc};

	always_comb begin
		phase_n   = phase_q;
		residue_n = residue_q;
		count_n   = count_q;
		stopped_n = stopped_q;
		poll_n    = poll_q;
		retries_n = retries_q;
		fsum_n    = fsum_q;
		error_n   = error_q;
		kind_n    = kind_q;
		request_n = request_q;
		hdr_we    = 1'b0;

		unique case (beat_s1.opcode)
			rmrc_pkg::OP_START: begin
				if (phase_q == PH_IDLE) begin
					poll_n    = (poll_q >= rmrc_pkg::POLL_LAST) ? 3'd1 : poll_q + 3'd1;
					retries_n = 8'd0;
					kind_n    = rmrc_pkg::KIND_NONE;
					request_n = ~poll_n[0];
					count_n   = '0;
					stopped_n = 1'b0;
					phase_n   = PH_WAIT;
				end
			end
			rmrc_pkg::OP_BYTE: begin
				if (phase_q == PH_IDLE) begin
					error_n = rmrc_pkg::ERR_STRAY;
				end else if (phase_q == PH_WAIT || !stopped_q) begin
					if (phase_q != PH_WAIT && beat_s1.line_flag && residue_q == 16'h0000) begin
						// line flag on a clean residue: the frame is complete, drop the byte
						stopped_n = 1'b1;
					end else begin
						hdr_we    = (count_src < CW'(rmrc_pkg::HDR_BYTES));
						residue_n = crc_next;
						phase_n   = PH_RCV;
						if (count_src == COUNT_HOLD) begin
							// buffer full: hold the count and stop reception
							count_n   = count_src;
							stopped_n = 1'b1;
						end else begin
							count_n   = count_src + 1'b1;
							stopped_n = 1'b0;
						end
					end
				end
			end
			rmrc_pkg::OP_TIMEOUT: begin
				if (phase_q != PH_IDLE) begin
					phase_n = PH_IDLE;
					error_n = verdict.code;
					kind_n  = verdict.kind;
					if (verdict.fail) begin
						retries_n = retries_inc;
						fsum_n    = fsum_sum[32] ? 32'hFFFF_FFFF : fsum_sum[31:0];
					end else begin
						retries_n = 8'd0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			residue_q <= rmrc_pkg::CRC_INIT;
			count_q   <= '0;
			stopped_q <= 1'b0;
			poll_q    <= 3'd0;
			retries_q <= 8'd0;
			fsum_q    <= 32'd0;
			error_q   <= rmrc_pkg::ERR_OK;
			kind_q    <= rmrc_pkg::KIND_NONE;
			request_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_n;
			residue_q <= residue_n;
			count_q   <= count_n;
			stopped_q <= stopped_n;
			poll_q    <= poll_n;
			retries_q <= retries_n;
			fsum_q    <= fsum_n;
			error_q   <= error_n;
			kind_q    <= kind_n;
			request_q <= request_n;
		end
	end

	// Header capture: first five reply bytes
	always_ff @(posedge clk) begin
		if (advance && hdr_we) begin
			hdr_q[count_src[2:0]] <= beat_s1.rx_byte;
		end
	end

	// Result beat shows the state after this item
	always_comb begin
		res.error_code   = error_n;
		res.reply_kind   = kind_n;
		res.version_word = (kind_n == rmrc_pkg::KIND_VERSION) ? {hdr_q[4], hdr_q[3]} : 16'h0000;
		res.request_kind = request_n;
		res.retry_count  = retries_n;
		res.error_total  = fsum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= res;
		end
	end

endmodule

[rtl/rmrc_checker.sv]
module rmrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input rmrc_pkg::out_beat_t out_data
);

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// Input is never stalled while the output side is empty
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// Version word only shows for a version reply
	a_version_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reply_kind != rmrc_pkg::KIND_VERSION
		|-> out_data.version_word == 16'h0000)
		else $error("version word set for a non-version reply");

	// A recognized reply means the retry count was cleared
	a_kind_retries: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reply_kind != rmrc_pkg::KIND_NONE
		|-> out_data.retry_count == 8'd0)
		else $error("retry count nonzero alongside a reply kind");

endmodule

bind rs485_master_reply_checker_core rmrc_checker u_rmrc_checker (.*);

[test/tb_rs485_master_reply_checker_core.sv]
module tb_rs485_master_reply_checker_core;

	// Keep the buffer small so that overruns are cheap to reach.
	localparam int          BUF_BYTES   = 12;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam int          HOLD_CYCLES = 150;
	localparam int          IDLE_LIMIT  = 1000;

	localparam rmrc_pkg::cfg_regs_t CFG_DEFAULTS =
		'{8'd1, 8'd3, 8'd6, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};

	typedef enum logic [1:0] {LINK_IDLE, LINK_WAIT, LINK_RCV} link_phase_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	rmrc_pkg::in_beat_t  in_data   = '0;
	logic                out_stall = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [7:0]          cfg_data  = '0;
	logic                in_stall;
	logic                out_valid;
	rmrc_pkg::out_beat_t out_data;

	// Status beats predicted for accepted input beats, oldest first.
	rmrc_pkg::out_beat_t pending_status_q [$];
	int        mismatches = 0;
	int        live_beats = 0;   // accepted beats that the block acts on
	logic      beat_is_live;
	logic      tx_steady = 1'b0;
	logic      rx_steady = 1'b0;
	int        hold_left = 0;

	// Mirror of the block: register file and poll/receive state.
	rmrc_pkg::cfg_regs_t cfg_model = CFG_DEFAULTS;
	link_phase_t m_link    = LINK_IDLE;
	logic [15:0] m_crc     = rmrc_pkg::CRC_INIT;
	logic [7:0]  m_hdr [rmrc_pkg::HDR_BYTES] = '{default: 8'h00};
	int          m_count   = 0;
	logic        m_stopped = 1'b0;
	logic [2:0]  m_poll    = '0;
	logic [7:0]  m_retries = '0;
	logic [31:0] m_fail_sum = '0;
	logic [3:0]  m_err     = rmrc_pkg::ERR_OK;
	logic [2:0]  m_kind    = rmrc_pkg::KIND_NONE;
	logic        m_request = 1'b0;

	rs485_master_reply_checker_core #(
		.BUFFER_BYTES(BUF_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Bitwise reflected CRC-16 step, independent of the nibble table.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [15:0] modbus_crc(input logic [7:0] frame [$]);
		logic [15:0] c;
		c = rmrc_pkg::CRC_INIT;
		foreach (frame[i])
			c = crc16_byte(c, frame[i]);
		return c;
	endfunction

	// Store one reply byte: header capture, residue update, overrun stop.
	function automatic void take_reply_byte(input logic [7:0] b);
		if (m_count < int'(rmrc_pkg::HDR_BYTES))
			m_hdr[m_count] = b;
		m_crc = crc16_byte(m_crc, b);
		m_count++;
		if (m_count >= BUF_BYTES - 1) begin
			m_count--;
			m_stopped = 1'b1;
		end
	endfunction

	function automatic void record_failure(input logic [3:0] code);
		m_err  = code;
		m_kind = rmrc_pkg::KIND_NONE;
		if (m_retries != 8'hFF)
			m_retries++;
		if (m_fail_sum > 32'hFFFF_FFFF - {24'd0, m_retries})
			m_fail_sum = 32'hFFFF_FFFF;
		else
			m_fail_sum += {24'd0, m_retries};
		m_link = LINK_IDLE;
	endfunction

	function automatic void record_success(input logic [2:0] kind);
		m_err     = rmrc_pkg::ERR_OK;
		m_kind    = kind;
		m_retries = '0;
		m_link    = LINK_IDLE;
	endfunction

	// Judge the reply: no reply, residue, address, then command and subcommand.
	function automatic void judge_reply();
		logic [7:0] cmd;
		logic [7:0] sub;
		logic       get_bad;
		get_bad = 1'b0;
		cmd = m_hdr[1];
		sub = m_hdr[2];
		if (m_link == LINK_WAIT) begin
			record_failure(rmrc_pkg::ERR_NO_REPLY);
			return;
		end
		if (m_crc != 16'h0000) begin
			record_failure((m_count == 0) ? rmrc_pkg::ERR_CRC_EMPTY : rmrc_pkg::ERR_CRC);
			return;
		end
		if (m_hdr[0] != cfg_model.device_address) begin
			record_failure(rmrc_pkg::ERR_ADDRESS);
			return;
		end
		if (cmd == cfg_model.get_command) begin
			if (sub == cfg_model.status_subcode) begin
				record_success(rmrc_pkg::KIND_STATUS);
				return;
			end
			if (sub == cfg_model.config_subcode) begin
				record_success(rmrc_pkg::KIND_CONFIG);
				return;
			end
			if (sub == cfg_model.errors_subcode) begin
				record_success(rmrc_pkg::KIND_ERRORS);
				return;
			end
			if (sub == cfg_model.version_subcode) begin
				record_success(rmrc_pkg::KIND_VERSION);
				return;
			end
			// Unknown get subcommand: fall through to the set check.
			get_bad = 1'b1;
		end
		if (cmd == cfg_model.set_command) begin
			if (sub == cfg_model.config_subcode)
				record_success(rmrc_pkg::KIND_CFG_ACK);
			else if (sub == cfg_model.commands_subcode)
				record_success(rmrc_pkg::KIND_CMD_ACK);
			else
				record_failure(rmrc_pkg::ERR_SET_SUB);
			return;
		end
		record_failure(get_bad ? rmrc_pkg::ERR_GET_SUB : rmrc_pkg::ERR_COMMAND);
	endfunction

	// Advance the mirror by one input beat and return the status beat it yields.
	function automatic rmrc_pkg::out_beat_t advance_reply_checker(input rmrc_pkg::in_beat_t beat);
		rmrc_pkg::out_beat_t res;
		beat_is_live = 1'b1;
		case (beat.opcode)
			rmrc_pkg::OP_START: begin
				if (m_link == LINK_IDLE) begin
					m_poll    = (m_poll >= rmrc_pkg::POLL_LAST) ? 3'd1 : m_poll + 3'd1;
					m_retries = '0;
					m_kind    = rmrc_pkg::KIND_NONE;
					m_request = ~m_poll[0];
					m_count   = 0;
					m_stopped = 1'b0;
					m_link    = LINK_WAIT;
				end else begin
					beat_is_live = 1'b0;
				end
			end
			rmrc_pkg::OP_BYTE: begin
				if (m_link == LINK_IDLE) begin
					m_err = rmrc_pkg::ERR_STRAY;
				end else if (m_link == LINK_WAIT) begin
					// First byte: restart the residue, ignore the line flag.
					m_crc     = rmrc_pkg::CRC_INIT;
					m_count   = 0;
					m_stopped = 1'b0;
					take_reply_byte(beat.rx_byte);
					m_link    = LINK_RCV;
				end else if (m_stopped) begin
					beat_is_live = 1'b0;
				end else if (beat.line_flag && m_crc == 16'h0000) begin
					m_stopped = 1'b1;
				end else begin
					take_reply_byte(beat.rx_byte);
				end
			end
			rmrc_pkg::OP_TIMEOUT: begin
				if (m_link != LINK_IDLE)
					judge_reply();
				else
					beat_is_live = 1'b0;
			end
			default: beat_is_live = 1'b0;
		endcase
		res.error_code   = m_err;
		res.reply_kind   = m_kind;
		res.version_word = (m_kind == rmrc_pkg::KIND_VERSION) ? {m_hdr[4], m_hdr[3]} : 16'h0000;
		res.request_kind = m_request;
		res.retry_count  = m_retries;
		res.error_total  = m_fail_sum;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall pattern, checker, watchdog
	// ------------------------------------------------------------------

	// Stall at random, hold off completely while a hold-off is running,
	// drop stalls entirely during steady stretches.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !rx_steady && ($urandom_range(0, 99) < 32);
		end
	end

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted status beat with the oldest prediction.
	always @(posedge clk) begin
		rmrc_pkg::out_beat_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_status_q.size() == 0) begin
				$display("%0t: status beat with nothing pending: actual %h", $time, out_data);
				mismatches++;
			end else begin
				want = pending_status_q.pop_front();
				check_field("error_code", 32'(want.error_code), 32'(out_data.error_code));
				check_field("reply_kind", 32'(want.reply_kind), 32'(out_data.reply_kind));
				check_field("version_word", 32'(want.version_word),
					32'(out_data.version_word));
				check_field("request_kind", 32'(want.request_kind),
					32'(out_data.request_kind));
				check_field("retry_count", 32'(want.retry_count), 32'(out_data.retry_count));
				check_field("error_total", want.error_total, out_data.error_total);
			end
		end
	end

	// End the run when neither channel has moved a beat for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one beat, with a random gap first unless the sender is steady.
	// Valid stays high on return so back-to-back beats follow without a gap.
	task automatic send_beat(input logic [1:0] op, input logic [7:0] data, input logic flag);
		rmrc_pkg::in_beat_t beat;
		beat.opcode    = op;
		beat.rx_byte   = data;
		beat.line_flag = flag;
		if (!tx_steady && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 32);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_status_q.push_back(advance_reply_checker(beat));
		if (beat_is_live)
			live_beats++;
	endtask

	// Noise beat of any opcode with random payload.
	task automatic send_noise();
		send_beat(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
	endtask

	// Drop valid and hold until every predicted status beat has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_status_q.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			rmrc_pkg::REG_DEVICE_ADDRESS:   cfg_model.device_address   = data;
			rmrc_pkg::REG_GET_COMMAND:      cfg_model.get_command      = data;
			rmrc_pkg::REG_SET_COMMAND:      cfg_model.set_command      = data;
			rmrc_pkg::REG_STATUS_SUBCODE:   cfg_model.status_subcode   = data;
			rmrc_pkg::REG_CONFIG_SUBCODE:   cfg_model.config_subcode   = data;
			rmrc_pkg::REG_ERRORS_SUBCODE:   cfg_model.errors_subcode   = data;
			rmrc_pkg::REG_VERSION_SUBCODE:  cfg_model.version_subcode  = data;
			rmrc_pkg::REG_COMMANDS_SUBCODE: cfg_model.commands_subcode = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Reprogram all registers once the block is empty; the pipeline is two
	// stages deep, and the task waits out anything still in flight first.
	task automatic set_config(input rmrc_pkg::cfg_regs_t c);
		drain();
		repeat (4) @(posedge clk);
		write_reg(rmrc_pkg::REG_DEVICE_ADDRESS, c.device_address);
		write_reg(rmrc_pkg::REG_GET_COMMAND, c.get_command);
		write_reg(rmrc_pkg::REG_SET_COMMAND, c.set_command);
		write_reg(rmrc_pkg::REG_STATUS_SUBCODE, c.status_subcode);
		write_reg(rmrc_pkg::REG_CONFIG_SUBCODE, c.config_subcode);
		write_reg(rmrc_pkg::REG_ERRORS_SUBCODE, c.errors_subcode);
		write_reg(rmrc_pkg::REG_VERSION_SUBCODE, c.version_subcode);
		write_reg(rmrc_pkg::REG_COMMANDS_SUBCODE, c.commands_subcode);
		cfg_we <= 1'b0;
	endtask

	// One poll: start, usually a reply (mostly well formed for the current registers),
	// optional idle-line marker and trailing junk, then the timeout.
	// Sprinkle noise beats of any opcode to break sequences now and then.
	task automatic run_poll();
		logic [7:0]  frame [$];
		logic [15:0] crc;
		int          pick;
		int          flip_pos;
		int          flip_bit;
		if ($urandom_range(0, 99) < 10)
			send_noise();
		send_beat(rmrc_pkg::OP_START, 8'($urandom), 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick >= 8) begin
			if (pick < 14) begin
				// Overlong reply: runs into the buffer limit.
				repeat (BUF_BYTES + 2) frame.push_back(8'($urandom));
			end else begin
				frame.push_back(($urandom_range(0, 99) < 88) ?
					cfg_model.device_address : 8'($urandom_range(0, 255)));
				pick = $urandom_range(0, 99);
				frame.push_back((pick < 45) ? cfg_model.get_command :
					(pick < 85) ? cfg_model.set_command : 8'($urandom_range(0, 255)));
				case ($urandom_range(0, 6))
					0: frame.push_back(cfg_model.status_subcode);
					1: frame.push_back(cfg_model.config_subcode);
					2: frame.push_back(cfg_model.errors_subcode);
					3: frame.push_back(cfg_model.version_subcode);
					4: frame.push_back(cfg_model.commands_subcode);
					default: frame.push_back(8'($urandom_range(0, 255)));
				endcase
				repeat ($urandom_range(0, BUF_BYTES - 7)) frame.push_back(8'($urandom));
				crc = modbus_crc(frame);
				frame.push_back(crc[7:0]);
				frame.push_back(crc[15:8]);
				if ($urandom_range(0, 99) < 8) begin
					flip_pos = $urandom_range(0, frame.size() - 1);
					flip_bit = $urandom_range(0, 7);
					frame[flip_pos] = frame[flip_pos] ^ (8'h01 << flip_bit);
				end
			end
			foreach (frame[i]) begin
				if ($urandom_range(0, 99) < 3)
					send_noise();
				send_beat(rmrc_pkg::OP_BYTE, frame[i], $urandom_range(0, 99) < 10);
			end
			if ($urandom_range(0, 99) < 40)
				send_beat(rmrc_pkg::OP_BYTE, 8'($urandom), 1'b1);
			repeat ($urandom_range(0, 2))
				send_beat(rmrc_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
		end
		send_beat(rmrc_pkg::OP_TIMEOUT, 8'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(input rmrc_pkg::cfg_regs_t c, input int goal);
		int stop_at;
		set_config(c);
		stop_at = live_beats + goal;
		while (live_beats < stop_at)
			run_poll();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Beats that arrive while idle: timeout and unused opcode do nothing,
	// a byte is flagged as stray.
	task automatic test_idle_items();
		send_beat(rmrc_pkg::OP_TIMEOUT, 8'h00, 1'b0);
		send_beat(OP_UNUSED, 8'hFF, 1'b1);
		send_beat(rmrc_pkg::OP_BYTE, 8'hFF, 1'b1);
	endtask

	// Good version reply. Writes all five header bytes, so no later judge or
	// version read can touch an unwritten entry. A second start while waiting
	// is ignored, the first byte's line flag is ignored, the idle-line marker
	// after a clean residue stops reception and later bytes are dropped.
	task automatic test_version_reply();
		logic [7:0]  frame [$];
		logic [15:0] crc;
		frame = {cfg_model.device_address, cfg_model.get_command,
			cfg_model.version_subcode, 8'h00, 8'hFF};
		crc = modbus_crc(frame);
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
		send_beat(rmrc_pkg::OP_START, 8'h00, 1'b0);
		send_beat(rmrc_pkg::OP_START, 8'hFF, 1'b1);
		foreach (frame[i])
			send_beat(rmrc_pkg::OP_BYTE, frame[i], i == 0);
		send_beat(rmrc_pkg::OP_BYTE, 8'hA5, 1'b1);
		send_beat(rmrc_pkg::OP_BYTE, 8'h5A, 1'b0);
		send_beat(rmrc_pkg::OP_TIMEOUT, 8'hFF, 1'b0);
	endtask

	task automatic test_missing_reply();
		send_beat(rmrc_pkg::OP_START, 8'h00, 1'b0);
		send_beat(rmrc_pkg::OP_TIMEOUT, 8'h00, 1'b0);
	endtask

	// Fill the buffer; the last bytes land after the stop and are ignored.
	task automatic test_buffer_overrun();
		send_beat(rmrc_pkg::OP_START, 8'h00, 1'b0);
		repeat (BUF_BYTES) send_beat(rmrc_pkg::OP_BYTE, 8'($urandom), 1'b0);
		send_beat(rmrc_pkg::OP_TIMEOUT, 8'h00, 1'b0);
	endtask

	// Hold the result side off while the sender keeps offering, so the block
	// fills and stalls its input; then pause until everything has drained.
	task automatic test_output_holdoff();
		hold_left = HOLD_CYCLES;
		run_poll();
		run_poll();
		drain();
	endtask

	task automatic test_random_polls();
		rmrc_pkg::cfg_regs_t c;
		// Steady stretch first: no gaps and no stalls on either side.
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_phase(CFG_DEFAULTS, 100);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		run_phase(CFG_DEFAULTS, 100);
		// Extremes: every register at zero, then at all ones.
		run_phase('0, 150);
		run_phase('1, 150);
		// Shared get/set command exercises the get-to-set fall-through.
		c = {$urandom, $urandom};
		c.set_command = c.get_command;
		run_phase(c, 150);
		c = {$urandom, $urandom};
		run_phase(c, 150);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_items();
		test_version_reply();
		test_missing_reply();
		test_buffer_overrun();
		test_output_holdoff();
		test_random_polls();
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
